// File: hdl/qmsp_pkg.sv
// Shared types and constants of the queued motion speed profiler.
`default_nettype none
package qmsp_pkg;

    localparam logic [2:0] FUNC_TICK      = 3'd0;
    localparam logic [2:0] FUNC_CHANGE    = 3'd1;
    localparam logic [2:0] FUNC_CHANGE_AT = 3'd2;
    localparam logic [2:0] FUNC_STOP_AT   = 3'd3;
    localparam logic [2:0] FUNC_CLEAR     = 3'd4;

    localparam logic [1:0] KIND_CHANGE    = 2'd1;
    localparam logic [1:0] KIND_CHANGE_AT = 2'd2;
    localparam logic [1:0] KIND_STOP_AT   = 2'd3;

    localparam logic [1:0] REG_MAX_SPEED      = 2'd0;
    localparam logic [1:0] REG_MAX_ACCEL      = 2'd1;
    localparam logic [1:0] REG_SPEED_STEP     = 2'd2;
    localparam logic [1:0] REG_DIST_TOLERANCE = 2'd3;

    localparam int APB_ADDR_W = 4;
    localparam int MAG_W      = 16;

    localparam logic [14:0] RST_MAX_SPEED      = 15'd2000;
    localparam logic [15:0] RST_MAX_ACCEL      = 16'd1000;
    localparam logic [11:0] RST_SPEED_STEP     = 12'd2;
    localparam logic [9:0]  RST_DIST_TOLERANCE = 10'd1;

    // Braking curve works in mm/s, so v*v is scaled by one thousand.
    localparam logic [9:0] ACCEL_SCALE = 10'd1000;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [15:0] cmd_speed;
        logic signed [31:0] cmd_distance;
        logic signed [31:0] right_distance;
        logic signed [31:0] left_distance;
    } in_t;

    typedef struct packed {
        logic signed [15:0] target_speed;
        logic               motion_done;
        logic               queue_dropped;
        logic [3:0]         queue_count;
    } out_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] speed;
        logic signed [31:0] distance;
    } entry_t;

    typedef struct packed {
        logic [14:0] max_speed;
        logic [15:0] max_accel;
        logic [11:0] speed_step;
        logic [9:0]  dist_tolerance;
    } cfg_t;

    typedef struct packed {
        logic       load;
        logic       do_queue;
        logic       do_clear;
        logic       do_ramp;
        logic       do_prep;
        logic       do_mul;
        logic       do_sum;
        logic       do_sq;
        logic       do_cmp;
        logic       do_fin;
        logic       out_load;
        logic [3:0] bit_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       queue_nz;
        logic [1:0] head_kind;
    } dp_status_t;

endpackage
`default_nettype wire

// File: hdl/queued_motion_speed_profiler_top.sv
// Top level of the queued motion speed profiler: register port and block wiring.
//
//  Port group  Direction  Handshake          Beat contents
//  s_*         in         s_valid/s_ready    func, speed, distance, wheel distances
//  m_*         out        m_valid/m_ready    target speed, done, dropped, count
//  APB         in/out     psel/penable       four configuration registers
//
// Queue, clear, non-distance ticks and idle ticks pass through S_DECODE and S_RESULT only.
// A distance tick also runs a 16-bit square root search that squares a trial value
// on a 16x16 multiplier in S_SQ and compares it in S_CMP for each result bit.
// Reset is synchronous; the queue memory needs no clearing pass.
// A held result stalls only the next item's final cycle, not its acceptance.
`default_nettype none
module queued_motion_speed_profiler_top #(
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire qmsp_pkg::in_t                   s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output qmsp_pkg::out_t                       m_data,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [qmsp_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    qmsp_pkg::cfg_t       cfg_reg, cfg_next;
    qmsp_pkg::dp_cmd_t    cmd;
    qmsp_pkg::dp_status_t status;
    logic                 wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (paddr[3:2])
                qmsp_pkg::REG_MAX_SPEED:      cfg_next.max_speed      = pwdata[14:0];
                qmsp_pkg::REG_MAX_ACCEL:      cfg_next.max_accel      = pwdata[15:0];
                qmsp_pkg::REG_SPEED_STEP:     cfg_next.speed_step     = pwdata[11:0];
                qmsp_pkg::REG_DIST_TOLERANCE: cfg_next.dist_tolerance = pwdata[9:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            qmsp_pkg::REG_MAX_SPEED:      prdata = 32'(cfg_reg.max_speed);
            qmsp_pkg::REG_MAX_ACCEL:      prdata = 32'(cfg_reg.max_accel);
            qmsp_pkg::REG_SPEED_STEP:     prdata = 32'(cfg_reg.speed_step);
            qmsp_pkg::REG_DIST_TOLERANCE: prdata = 32'(cfg_reg.dist_tolerance);
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_speed      <= qmsp_pkg::RST_MAX_SPEED;
            cfg_reg.max_accel      <= qmsp_pkg::RST_MAX_ACCEL;
            cfg_reg.speed_step     <= qmsp_pkg::RST_SPEED_STEP;
            cfg_reg.dist_tolerance <= qmsp_pkg::RST_DIST_TOLERANCE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    qmsp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    qmsp_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .cmd     (cmd),
        .status  (status),
        .m_data  (m_data)
    );

    // An accepted beat always makes the block busy, so s_ready drops after acceptance.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while previous item in flight");

    // Completion comes only from ticks and refusal only from queue commands.
    a_done_xor_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.motion_done && m_data.queue_dropped))
        else $error("done and dropped reported together");

    // A refused command means the queue stayed full.
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.queue_dropped |-> m_data.queue_count == 4'(QUEUE_DEPTH))
        else $error("command dropped with room in queue");

endmodule
`default_nettype wire

// File: hdl/qmsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module qmsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: hdl/qmsp_dp.sv
// Datapath: command queue, speed ramp, braking curve and result register.
`default_nettype none
module qmsp_dp #(
    parameter int QUEUE_DEPTH = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire qmsp_pkg::in_t        s_data,
    input  wire qmsp_pkg::cfg_t       cfg,
    input  wire qmsp_pkg::dp_cmd_t    cmd,
    output qmsp_pkg::dp_status_t      status,
    output qmsp_pkg::out_t            m_data
);

    localparam int PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = $bits(qmsp_pkg::entry_t);
    localparam int MAG_W_L = qmsp_pkg::MAG_W;

    qmsp_pkg::in_t      item_reg, item_next;
    qmsp_pkg::entry_t   entry_reg, entry_next, head_entry;
    qmsp_pkg::out_t     out_reg, out_next;
    logic [PTR_W-1:0]   head_reg, head_next, tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic signed [15:0] cur_reg, cur_next, cruise_reg, cruise_next;
    logic               captured_reg, captured_next, finished_reg, finished_next;
    logic               done_reg, done_next, dropped_reg, dropped_next;
    logic               neg_reg, neg_next;
    logic [32:0]        aerr_reg, aerr_next;
    logic [48:0]        prod_reg, prod_next;
    logic [31:0]        vv_reg, vv_next;
    logic [50:0]        n_reg, n_next;
    logic [MAG_W_L-1:0] mag_reg, mag_next;
    logic [31:0]        sq_reg, sq_next;

    logic               ram_we;
    qmsp_pkg::entry_t   ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    qmsp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (ram_wdata),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign head_entry = qmsp_pkg::entry_t'(ram_rdata);

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        logic signed [16:0] lim, spd17, diff, st, cap, lmag, cspd;
        logic signed [15:0] new_spd;
        logic signed [31:0] qdist;
        logic signed [33:0] sum, robot, err;
        logic signed [31:0] vsq;
        logic [CNT_W-1:0]   cnt;
        logic [MAG_W_L-1:0] trial;
        logic               pop, fin;

        item_next     = item_reg;
        entry_next    = entry_reg;
        out_next      = out_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        cur_next      = cur_reg;
        cruise_next   = cruise_reg;
        captured_next = captured_reg;
        finished_next = finished_reg;
        done_next     = done_reg;
        dropped_next  = dropped_reg;
        neg_next      = neg_reg;
        aerr_next     = aerr_reg;
        prod_next     = prod_reg;
        vv_next       = vv_reg;
        n_next        = n_reg;
        mag_next      = mag_reg;
        sq_next       = sq_reg;
        ram_we        = 1'b0;
        ram_wdata     = '0;
        pop           = 1'b0;
        fin           = finished_reg;
        lim           = 17'(signed'({2'b00, cfg.max_speed}));
        spd17         = 17'(item_reg.cmd_speed);
        st            = 17'(signed'({5'b00000, cfg.speed_step}));
        diff          = 17'(head_entry.speed) - 17'(cur_reg);
        cap           = (cruise_reg < 0) ? -17'(cruise_reg) : 17'(cruise_reg);
        lmag          = 17'(signed'({1'b0, mag_reg}));
        trial         = mag_reg | (MAG_W_L'(1) << cmd.bit_idx);
        sum           = 34'(item_reg.right_distance) + 34'(item_reg.left_distance);
        // Arithmetic shift rounds down, so negative sums get one added first to round toward zero.
        robot         = (sum + 34'(signed'({1'b0, sum[33]}))) >>> 1;
        err           = 34'(entry_reg.distance) - robot;
        vsq           = entry_reg.speed * entry_reg.speed;
        qdist         = item_reg.cmd_distance;
        cnt           = count_reg;
        new_spd       = cur_reg;
        cspd          = '0;

        if (cmd.load) begin
            item_next    = s_data;
            done_next    = 1'b0;
            dropped_next = 1'b0;
        end

        if (cmd.do_queue) begin
            if (spd17 > lim) begin
                spd17 = lim;
            end
            if (spd17 < -lim) begin
                spd17 = -lim;
            end
            if (item_reg.func == qmsp_pkg::FUNC_STOP_AT) begin
                spd17 = '0;
            end
            if (item_reg.func == qmsp_pkg::FUNC_CHANGE) begin
                qdist = '0;
            end
            if (count_reg != '0 && finished_reg) begin
                head_next     = ptr_inc(head_reg);
                cnt           = count_reg - 1'b1;
                finished_next = 1'b0;
                captured_next = 1'b0;
                cruise_next   = '0;
            end
            if (cnt == CNT_W'(QUEUE_DEPTH)) begin
                dropped_next = 1'b1;
                count_next   = cnt;
            end else begin
                ram_we         = 1'b1;
                ram_wdata.kind = item_reg.func[1:0];
                ram_wdata.speed    = spd17[15:0];
                ram_wdata.distance = qdist;
                tail_next      = ptr_inc(tail_reg);
                count_next     = cnt + 1'b1;
            end
        end

        if (cmd.do_clear) begin
            head_next     = '0;
            tail_next     = '0;
            count_next    = '0;
            finished_next = 1'b0;
            captured_next = 1'b0;
            cruise_next   = '0;
        end

        if (cmd.do_ramp) begin
            if (diff > st) begin
                new_spd = 16'(17'(cur_reg) + st);
            end else if (diff < -st) begin
                new_spd = 16'(17'(cur_reg) - st);
            end else begin
                new_spd = head_entry.speed;
            end
            cur_next = new_spd;
            if (new_spd == head_entry.speed) begin
                done_next = 1'b1;
                pop       = 1'b1;
            end
        end

        if (cmd.do_prep) begin
            entry_next = head_entry;
            if (!captured_reg) begin
                cruise_next   = cur_reg;
                captured_next = 1'b1;
            end
        end

        if (cmd.do_mul) begin
            // Error is formed from the entry captured in the previous cycle.
            neg_next  = err[33];
            aerr_next = err[33] ? 33'(-err) : 33'(err);
            vv_next   = 32'(vsq);
        end

        if (cmd.do_sum) begin
            prod_next = 49'(aerr_reg) * 49'(cfg.max_accel);
            mag_next  = '0;
        end

        if (cmd.do_sq) begin
            if (cmd.bit_idx == 4'(MAG_W_L - 1)) begin
                n_next = {prod_reg, 1'b0} + 51'(42'(vv_reg) * 42'(qmsp_pkg::ACCEL_SCALE));
            end
            sq_next = 32'(trial) * 32'(trial);
        end

        if (cmd.do_cmp) begin
            if (51'(42'(sq_reg) * 42'(qmsp_pkg::ACCEL_SCALE)) <= n_reg) begin
                mag_next = trial;
            end
        end

        if (cmd.do_fin) begin
            if (lmag > cap) begin
                lmag = cap;
            end
            cspd    = neg_reg ? -lmag : lmag;
            new_spd = cspd[15:0];
            if (aerr_reg <= 33'(cfg.dist_tolerance)) begin
                new_spd = entry_reg.speed;
                if (!finished_reg) begin
                    done_next = 1'b1;
                end
                fin = 1'b1;
            end
            cur_next      = new_spd;
            finished_next = fin;
            if (entry_reg.kind == qmsp_pkg::KIND_CHANGE_AT) begin
                pop = fin;
            end else begin
                pop = fin && (count_reg > CNT_W'(1));
            end
        end

        if (pop) begin
            head_next     = ptr_inc(head_reg);
            count_next    = count_reg - 1'b1;
            finished_next = 1'b0;
            captured_next = 1'b0;
            cruise_next   = '0;
        end

        if (cmd.out_load) begin
            out_next.target_speed  = cur_reg;
            out_next.motion_done   = done_reg;
            out_next.queue_dropped = dropped_reg;
            out_next.queue_count   = 4'(count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            cur_reg      <= '0;
            cruise_reg   <= '0;
            captured_reg <= 1'b0;
            finished_reg <= 1'b0;
            done_reg     <= 1'b0;
            dropped_reg  <= 1'b0;
        end else begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            cur_reg      <= cur_next;
            cruise_reg   <= cruise_next;
            captured_reg <= captured_next;
            finished_reg <= finished_next;
            done_reg     <= done_next;
            dropped_reg  <= dropped_next;
        end
        item_reg  <= item_next;
        entry_reg <= entry_next;
        out_reg   <= out_next;
        neg_reg   <= neg_next;
        aerr_reg  <= aerr_next;
        prod_reg  <= prod_next;
        vv_reg    <= vv_next;
        n_reg     <= n_next;
        mag_reg   <= mag_next;
        sq_reg    <= sq_next;
    end

    assign status.func      = item_reg.func;
    assign status.queue_nz  = (count_reg != '0);
    assign status.head_kind = head_entry.kind;
    assign m_data           = out_reg;

endmodule
`default_nettype wire

// File: hdl/qmsp_ctrl.sv
// Controller: sequences each item through the datapath and owns the handshakes.
`default_nettype none
module qmsp_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    input  wire qmsp_pkg::dp_status_t status,
    output qmsp_pkg::dp_cmd_t         cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_PREP   = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_SQ     = 3'd4;
    localparam logic [2:0] S_CMP    = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;
    localparam logic [2:0] S_RESULT = 3'd7;

    logic [2:0] state_reg, state_next;
    logic [3:0] bit_reg, bit_next;
    logic       m_valid_reg, m_valid_next;

    always_comb begin
        cmd          = '0;
        cmd.bit_idx  = bit_reg;
        state_next   = state_reg;
        bit_next     = bit_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_RESULT;
                if (status.func inside {qmsp_pkg::FUNC_CHANGE, qmsp_pkg::FUNC_CHANGE_AT,
                                        qmsp_pkg::FUNC_STOP_AT}) begin
                    cmd.do_queue = 1'b1;
                end else if (status.func == qmsp_pkg::FUNC_CLEAR) begin
                    cmd.do_clear = 1'b1;
                end else if (status.func == qmsp_pkg::FUNC_TICK && status.queue_nz) begin
                    if (status.head_kind == qmsp_pkg::KIND_CHANGE) begin
                        cmd.do_ramp = 1'b1;
                    end else if (status.head_kind inside {qmsp_pkg::KIND_CHANGE_AT,
                                                          qmsp_pkg::KIND_STOP_AT}) begin
                        cmd.do_prep = 1'b1;
                        state_next  = S_PREP;
                    end
                end
            end
            S_PREP: begin
                cmd.do_mul = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                cmd.do_sum = 1'b1;
                bit_next   = 4'(qmsp_pkg::MAG_W - 1);
                state_next = S_SQ;
            end
            S_SQ: begin
                cmd.do_sq  = 1'b1;
                state_next = S_CMP;
            end
            S_CMP: begin
                cmd.do_cmp = 1'b1;
                if (bit_reg == '0) begin
                    state_next = S_FIN;
                end else begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = S_SQ;
                end
            end
            S_FIN: begin
                cmd.do_fin = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            bit_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            bit_reg     <= bit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire
